// ===== rtl/dda_line_rasterizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top_assert.svh
// Assertion macros used by the line rasterizer checker dlr_checker.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_TOP_ASSERT_SVH
`define DDA_LINE_RASTERIZER_TOP_ASSERT_SVH

// Clocked assertion, quiet while reset is asserted.
`define DLR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked during reset.
`define DLR_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// Types and constants of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned TILE_SIZE_DEF = 64;
	localparam int unsigned FRAC_BITS_DEF = 4;
	localparam int unsigned TILE_SIZE_MAX = 64;

	// Field widths
	localparam int unsigned COORD_W = 10;
	localparam int unsigned PIX_W   = 6;
	localparam int unsigned COLOR_W = 32;
	localparam int unsigned DEPTH_W = 16;

	// Slope is signed Q1.12, magnitude at most 1.0
	localparam int unsigned SLOPE_FRAC = 12;
	localparam int unsigned QUOT_W     = SLOPE_FRAC + 1;
	localparam int unsigned SLOPE_W    = QUOT_W + 1;
	localparam int unsigned DIV_STEPS  = QUOT_W;
	localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

	// Minor accumulator and pixel counter
	localparam int unsigned ACC_W = COORD_W + SLOPE_FRAC + 2;
	localparam int unsigned CNT_W = $clog2(TILE_SIZE_MAX + 1);

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Input beat
	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] color;
	} seg_in_t;

	// Output beat
	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic [DEPTH_W-1:0] pixel_depth;
		logic               last;
	} pixel_t;

	// Classified segment handed from front to back
	typedef struct packed {
		logic               xmajor;
		logic               dmin_neg;
		logic [COORD_W-1:0] dmin_abs;
		logic [COORD_W-1:0] dmaj;
		logic [ACC_W-1:0]   acc0;
		logic [PIX_W-1:0]   first_pix;
		logic [CNT_W-1:0]   count;
		logic [COLOR_W-1:0] color;
	} seg_desc_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== rtl/dda_line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// DDA line rasterizer for one segment in a square tile.
// ----------------------------------------------------------------------------
// Usage:
//   A segment beat is taken at a clock edge with start high and busy low.
//   Endpoints are unsigned Q6.4, color is carried to every pixel.
//   depth_we writes depth_wdata into the layer depth register; write it
//   only while no segment is in flight.
//   Each pixel is shown for one cycle with pixel_valid high; the final pixel
//   of a segment has pixel.last set. The receiver cannot stall the block.
// Flow:
//   Setup is one queue pop plus the bit-serial slope divider, then the walker
//   emits one pixel per cycle, so a segment of N pixels (N up to TILE_SIZE)
//   holds the back end for its setup and its N pixels. The front end and a
//   two-entry queue keep taking segments meanwhile; busy rises only when
//   both are full.
// Reset:
//   arst_n clears the queue, the sequencer, the output strobe and the depth.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_top #(
	parameter int unsigned TILE_SIZE = dlr_pkg::TILE_SIZE_DEF,
	parameter int unsigned FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  dlr_pkg::seg_in_t            segment,
	input  logic                        depth_we,
	input  logic [dlr_pkg::DEPTH_W-1:0] depth_wdata,
	output logic                        pixel_valid,
	output dlr_pkg::pixel_t             pixel
);

	logic [dlr_pkg::DEPTH_W-1:0] layer_depth_q;
	dlr_pkg::queue_stat_t        q_stat;
	dlr_pkg::seg_desc_t          push_desc, pop_desc;
	logic                        push, pop;

	// Layer depth register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_depth_q <= '0;
		end else if (depth_we) begin
			layer_depth_q <= depth_wdata;
		end
	end

	dlr_front #(
		.TILE_SIZE (TILE_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.segment (segment),
		.q_stat  (q_stat),
		.push    (push),
		.desc    (push_desc)
	);

	dlr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (push_desc),
		.pop     (pop),
		.rd_desc (pop_desc),
		.q_stat  (q_stat)
	);

	dlr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.rd_desc     (pop_desc),
		.pop         (pop),
		.layer_depth (layer_depth_q),
		.pixel_valid (pixel_valid),
		.pixel       (pixel)
	);

endmodule

// ===== rtl/dlr_front.sv =====
// ----------------------------------------------------------------------------
// dlr_front
// Accepts segments, picks the major axis, orders endpoints and sizes the walk.
// ----------------------------------------------------------------------------
module dlr_front #(
	parameter int unsigned TILE_SIZE = dlr_pkg::TILE_SIZE_DEF,
	parameter int unsigned FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dlr_pkg::seg_in_t    segment,
	input  dlr_pkg::queue_stat_t q_stat,
	output logic                push,
	output dlr_pkg::seg_desc_t  desc
);

	localparam int unsigned CW     = dlr_pkg::COORD_W;
	localparam int unsigned MIN_SH = dlr_pkg::SLOPE_FRAC - FRAC_BITS;

	dlr_pkg::seg_in_t seg_s1;
	logic             valid_s1;
	logic             accept;

	logic signed [CW:0] dx, dy, dmin;
	logic [CW-1:0]      adx, ady;
	logic               xmajor, swap;
	logic [CW-1:0]      maj_a, maj_b, min_a, min_b;
	logic [CW-1:0]      maj0, maj1, min0, min1;
	logic [CW-1:0]      first_c, last_c;
	logic [CW:0]        cnt_raw;

	// Stage holds one beat until the queue takes it
	assign push   = valid_s1 && !q_stat.full;
	assign busy   = valid_s1 && q_stat.full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1 <= segment;
		end
	end

	// Axis choice and endpoint ordering
	always_comb begin
		dx  = $signed({1'b0, seg_s1.end_x}) - $signed({1'b0, seg_s1.start_x});
		dy  = $signed({1'b0, seg_s1.end_y}) - $signed({1'b0, seg_s1.start_y});
		adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
		ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
		xmajor = adx > ady;
		if (xmajor) begin
			maj_a = seg_s1.start_x;
			maj_b = seg_s1.end_x;
			min_a = seg_s1.start_y;
			min_b = seg_s1.end_y;
		end else begin
			maj_a = seg_s1.start_y;
			maj_b = seg_s1.end_y;
			min_a = seg_s1.start_x;
			min_b = seg_s1.end_x;
		end
		swap = maj_a > maj_b;
		maj0 = swap ? maj_b : maj_a;
		maj1 = swap ? maj_a : maj_b;
		min0 = swap ? min_b : min_a;
		min1 = swap ? min_a : min_b;
		dmin = $signed({1'b0, min1}) - $signed({1'b0, min0});
	end

	// Walk length: integer major span, clipped to the tile
	always_comb begin
		first_c = maj0 >> FRAC_BITS;
		last_c  = maj1 >> FRAC_BITS;
		cnt_raw = {1'b0, last_c} - {1'b0, first_c} + (CW+1)'(1);
	end

	always_comb begin
		desc.xmajor    = xmajor;
		desc.dmin_neg  = dmin[CW];
		desc.dmin_abs  = dmin[CW] ? CW'(-dmin) : dmin[CW-1:0];
		desc.dmaj      = maj1 - maj0;
		desc.acc0      = dlr_pkg::ACC_W'(min0) << MIN_SH;
		desc.first_pix = first_c[dlr_pkg::PIX_W-1:0];
		desc.count     = (cnt_raw > (CW+1)'(TILE_SIZE)) ? dlr_pkg::CNT_W'(TILE_SIZE)
			: cnt_raw[dlr_pkg::CNT_W-1:0];
		desc.color     = seg_s1.color;
	end

endmodule

// ===== rtl/dlr_queue.sv =====
// ----------------------------------------------------------------------------
// dlr_queue
// Short FIFO of classified segments between front and back.
// ----------------------------------------------------------------------------
module dlr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dlr_pkg::seg_desc_t   wr_desc,
	input  logic                 pop,
	output dlr_pkg::seg_desc_t   rd_desc,
	output dlr_pkg::queue_stat_t q_stat
);

	localparam int unsigned DEPTH = dlr_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dlr_pkg::seg_desc_t entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;

	assign q_stat.full  = fill_q == CNT_W'(DEPTH);
	assign q_stat.empty = fill_q == '0;
	assign rd_desc      = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

// ===== rtl/dlr_back.sv =====
// ----------------------------------------------------------------------------
// dlr_back
// Slope divider and DDA walker: one pixel per cycle once the slope is known.
// ----------------------------------------------------------------------------
module dlr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dlr_pkg::queue_stat_t        q_stat,
	input  dlr_pkg::seg_desc_t          rd_desc,
	output logic                        pop,
	input  logic [dlr_pkg::DEPTH_W-1:0] layer_depth,
	output logic                        pixel_valid,
	output dlr_pkg::pixel_t             pixel
);

	localparam int unsigned CW    = dlr_pkg::COORD_W;
	localparam int unsigned ACC_W = dlr_pkg::ACC_W;
	localparam int unsigned PW    = dlr_pkg::PIX_W;
	localparam int unsigned QW    = dlr_pkg::QUOT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	state_t                           state_q;
	dlr_pkg::seg_desc_t               desc_q;
	logic [CW:0]                      rem_q;
	logic [QW-1:0]                    quo_q;
	logic [dlr_pkg::STEP_W-1:0]       step_q;
	logic signed [dlr_pkg::SLOPE_W-1:0] slope_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic [PW-1:0]                    maj_q;
	logic [dlr_pkg::CNT_W-1:0]        left_q;
	logic                             pixel_valid_q;
	dlr_pkg::pixel_t                  pixel_q;

	logic            ge;
	logic [CW:0]     rem_sub;
	logic [QW-1:0]   quo_fin;
	logic            div_done;
	logic            acc_neg;
	logic [ACC_W-1:0] acc_mag;
	logic [PW-1:0]   min_mag, min_pix;
	logic            last_pix;

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	// One restoring-division step: |dmin| << 12 / dmaj
	always_comb begin
		ge       = rem_q >= {1'b0, desc_q.dmaj};
		rem_sub  = ge ? rem_q - {1'b0, desc_q.dmaj} : rem_q;
		quo_fin  = {quo_q[QW-2:0], ge};
		div_done = step_q == dlr_pkg::STEP_W'(dlr_pkg::DIV_STEPS - 1);
	end

	// Minor coordinate: accumulator truncated toward zero, wrapped to 6 bits
	always_comb begin
		acc_neg  = acc_q[ACC_W-1];
		acc_mag  = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		min_mag  = acc_mag[dlr_pkg::SLOPE_FRAC +: PW];
		min_pix  = acc_neg ? PW'(-min_mag) : min_mag;
		last_pix = left_q == dlr_pkg::CNT_W'(1);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pixel_valid_q <= 1'b0;
		end else begin
			pixel_valid_q <= state_q == ST_WALK;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (last_pix) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					desc_q <= rd_desc;
					rem_q  <= {1'b0, rd_desc.dmin_abs};
					quo_q  <= '0;
					step_q <= '0;
					acc_q  <= $signed(rd_desc.acc0);
					maj_q  <= rd_desc.first_pix;
					left_q <= rd_desc.count;
				end
			end
			ST_DIV: begin
				rem_q  <= {rem_sub[CW-1:0], 1'b0};
				quo_q  <= quo_fin;
				step_q <= step_q + dlr_pkg::STEP_W'(1);
				if (div_done) begin
					if (desc_q.dmaj == '0) begin
						slope_q <= '0;
					end else if (desc_q.dmin_neg) begin
						slope_q <= -$signed({1'b0, quo_fin});
					end else begin
						slope_q <= $signed({1'b0, quo_fin});
					end
				end
			end
			ST_WALK: begin
				pixel_q.pixel_x     <= desc_q.xmajor ? maj_q : min_pix;
				pixel_q.pixel_y     <= desc_q.xmajor ? min_pix : maj_q;
				pixel_q.pixel_color <= desc_q.color;
				pixel_q.pixel_depth <= layer_depth;
				pixel_q.last        <= last_pix;
				acc_q  <= acc_q + ACC_W'(slope_q);
				maj_q  <= maj_q + PW'(1);
				left_q <= left_q - dlr_pkg::CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

endmodule

// ===== rtl/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// dlr_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_top_assert.svh"

module dlr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            pixel_valid,
	input dlr_pkg::pixel_t pixel
);

	// No pixel beat while reset is held
	`DLR_ASSERT_RST(a_rst_quiet, !arst_n |-> !pixel_valid, "pixel beat during reset")

	// A segment's pixels come back to back with the same color and depth
	`DLR_ASSERT(a_seg_run, pixel_valid && !pixel.last |=> pixel_valid && $stable(pixel.pixel_color) && $stable(pixel.pixel_depth), "segment run broken")

	// Major coordinate advances by one between pixels of a segment
	`DLR_ASSERT(a_major_step, pixel_valid && !pixel.last |=> (pixel.pixel_x == $past(pixel.pixel_x) + 6'd1) || (pixel.pixel_y == $past(pixel.pixel_y) + 6'd1), "major axis did not step")

	// The slope setup leaves a gap after the final pixel
	`DLR_ASSERT(a_gap_after_last, pixel_valid && pixel.last |=> !pixel_valid, "no gap after last pixel")

endmodule

bind dda_line_rasterizer_top dlr_checker u_dlr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel       (pixel)
);

// ===== bench/dda_line_rasterizer_checker.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer_checker
// Watches the segment and pixel channels of the line rasterizer, predicts
// the pixel stream of every accepted segment and compares it beat by beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer_checker
	import dlr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  seg_in_t            segment,
	input  logic               depth_we,
	input  logic [DEPTH_W-1:0] depth_wdata,
	input  logic               pixel_valid,
	input  pixel_t             pixel,
	output int                 errors,
	output int                 pending
);

	localparam int FRAC     = 4;
	localparam int TILE     = 64;
	localparam int MIN_LIFT = SLOPE_FRAC - FRAC;

	pixel_t             predicted_pixels[$];
	logic [DEPTH_W-1:0] depth_shadow;

	// one line per mismatch, counted
	task automatic report(string what, longint got, longint want);
		$display("[%0t] pixel mismatch, %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	// Q.12 value truncated toward zero
	function automatic int trunc_q12(int v);
		if (v < 0)
			return -((-v) >>> SLOPE_FRAC);
		return v >>> SLOPE_FRAC;
	endfunction

	// walk the segment along its major axis and queue every pixel
	function automatic void rasterize_segment(seg_in_t s, logic [DEPTH_W-1:0] depth);
		int     sx, sy, ex, ey, adx, ady, maj0, maj1, min0, min1, t;
		int     slope, first, count, minor;
		bit     xmajor;
		pixel_t p;
		sx = int'(s.start_x);
		sy = int'(s.start_y);
		ex = int'(s.end_x);
		ey = int'(s.end_y);
		adx = (ex > sx) ? ex - sx : sx - ex;
		ady = (ey > sy) ? ey - sy : sy - ey;
		xmajor = adx > ady;
		if (xmajor) begin
			maj0 = sx; maj1 = ex; min0 = sy; min1 = ey;
		end else begin
			maj0 = sy; maj1 = ey; min0 = sx; min1 = ex;
		end
		// order along the major axis, ties keep input order
		if (maj0 > maj1) begin
			t = maj0; maj0 = maj1; maj1 = t;
			t = min0; min0 = min1; min1 = t;
		end
		if (maj1 == maj0)
			slope = 0;
		else
			slope = ((min1 - min0) * (1 << SLOPE_FRAC)) / (maj1 - maj0);
		first = maj0 >> FRAC;
		count = (maj1 >> FRAC) - first + 1;
		if (count > TILE)
			count = TILE;
		for (int k = 0; k < count; k++) begin
			minor = trunc_q12(min0 * (1 << MIN_LIFT) + slope * k);
			p.pixel_x     = PIX_W'(xmajor ? first + k : minor);
			p.pixel_y     = PIX_W'(xmajor ? minor : first + k);
			p.pixel_color = s.color;
			p.pixel_depth = depth;
			p.last        = (k == count - 1);
			predicted_pixels.push_back(p);
		end
	endfunction

	// compare pixel beats, then queue new segments, then track the depth
	always @(posedge clk) begin
		pixel_t want;
		if (!arst_n) begin
			depth_shadow = '0;
			predicted_pixels.delete();
		end else begin
			if (pixel_valid) begin
				if (predicted_pixels.size() == 0) begin
					report("beat with nothing expected", pixel, 0);
				end else begin
					want = predicted_pixels.pop_front();
					if (pixel.pixel_x !== want.pixel_x)
						report("pixel_x", pixel.pixel_x, want.pixel_x);
					if (pixel.pixel_y !== want.pixel_y)
						report("pixel_y", pixel.pixel_y, want.pixel_y);
					if (pixel.pixel_color !== want.pixel_color)
						report("pixel_color", pixel.pixel_color, want.pixel_color);
					if (pixel.pixel_depth !== want.pixel_depth)
						report("pixel_depth", pixel.pixel_depth, want.pixel_depth);
					if (pixel.last !== want.last)
						report("last", pixel.last, want.last);
				end
			end
			if (start && !busy)
				rasterize_segment(segment, depth_shadow);
			if (depth_we)
				depth_shadow = depth_wdata;
		end
		pending = predicted_pixels.size();
	end

endmodule

// ===== bench/dda_line_rasterizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top_tb
// Drives segments into the line rasterizer: a directed set of corner cases
// at the reset depth, then random phases at several layer depths with
// random sender gaps, one phase without gaps. A checker beside the block
// predicts and compares every pixel beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_rasterizer_top_tb;
	import dlr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 60;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	seg_in_t            segment;
	logic               depth_we;
	logic [DEPTH_W-1:0] depth_wdata;
	logic               pixel_valid;
	pixel_t             pixel;
	int                 errors;
	int                 pending;
	int                 cycles = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	dda_line_rasterizer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.segment     (segment),
		.depth_we    (depth_we),
		.depth_wdata (depth_wdata),
		.pixel_valid (pixel_valid),
		.pixel       (pixel)
	);

	dda_line_rasterizer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.segment     (segment),
		.depth_we    (depth_we),
		.depth_wdata (depth_wdata),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.errors      (errors),
		.pending     (pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dda_line_rasterizer_top_tb: errors");
			$finish;
		end
	end

	function automatic logic [COORD_W-1:0] clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > 1023)
			return '1;
		return COORD_W'(v);
	endfunction

	function automatic seg_in_t make_seg(int sx, int sy, int ex, int ey,
			logic [COLOR_W-1:0] color);
		seg_in_t s;
		s.start_x = clamp_coord(sx);
		s.start_y = clamp_coord(sy);
		s.end_x   = clamp_coord(ex);
		s.end_y   = clamp_coord(ey);
		s.color   = color;
		return s;
	endfunction

	// mostly back-to-back or short gaps, a few long ones
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// random segment: mostly short, some spanning the tile, some degenerate
	function automatic seg_in_t random_seg();
		int sx, sy, d, r;
		logic [COLOR_W-1:0] c;
		sx = $urandom_range(0, 1023);
		sy = $urandom_range(0, 1023);
		c  = $urandom;
		r  = $urandom_range(0, 9);
		if (r < 5)
			return make_seg(sx, sy, sx + $urandom_range(0, 160) - 80,
				sy + $urandom_range(0, 160) - 80, c);
		if (r < 8)
			return make_seg(sx, sy, $urandom_range(0, 1023), $urandom_range(0, 1023), c);
		if (r == 8) begin
			case ($urandom_range(0, 2))
				0: return make_seg(sx, sy, sx, sy, c);
				1: return make_seg(sx, sy, $urandom_range(0, 1023), sy, c);
				default: return make_seg(sx, sy, sx, $urandom_range(0, 1023), c);
			endcase
		end
		// equal deltas, either direction
		d = $urandom_range(0, 300);
		if ($urandom_range(0, 1))
			return make_seg(sx, sy, (sx + d <= 1023) ? sx + d : sx - d,
				(sy >= d) ? sy - d : sy + d, c);
		return make_seg(sx, sy, (sx >= d) ? sx - d : sx + d,
			(sy + d <= 1023) ? sy + d : sy - d, c);
	endfunction

	// hold the segment until the block takes it
	task automatic send_segment(seg_in_t s);
		segment <= s;
		start   <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and wait for every predicted pixel
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_depth(logic [DEPTH_W-1:0] value);
		depth_wdata <= value;
		depth_we    <= 1'b1;
		@(posedge clk);
		depth_we    <= 1'b0;
	endtask

	task automatic random_phase(int items, bit gaps);
		for (int i = 0; i < items; i++) begin
			send_segment(random_seg());
			if (gaps)
				hold_off(random_gap());
		end
	endtask

	initial begin
		seg_in_t directed[$];
		arst_n      <= 1'b0;
		start       <= 1'b0;
		segment     <= '0;
		depth_we    <= 1'b0;
		depth_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases at the reset depth
		directed.push_back(make_seg(0, 0, 0, 0, 32'h0000_0000));          // zero length, origin
		directed.push_back(make_seg(1023, 1023, 1023, 1023, 32'hFFFF_FFFF));
		directed.push_back(make_seg(100, 200, 100, 200, 32'h1234_5678));
		directed.push_back(make_seg(0, 0, 1023, 0, 32'hFFFF_FFFF));       // longest, spans the tile
		directed.push_back(make_seg(1023, 5, 0, 5, 32'hA5A5_A5A5));       // reversed x
		directed.push_back(make_seg(5, 1023, 5, 0, 32'h5A5A_5A5A));       // reversed y
		directed.push_back(make_seg(0, 0, 1023, 1023, 32'h8000_0001));    // equal deltas
		directed.push_back(make_seg(320, 0, 0, 320, 32'h7FFF_FFFE));
		directed.push_back(make_seg(12, 5, 40, 0, 32'h0F0F_0F0F));        // sum dips below zero
		directed.push_back(make_seg(1022, 15, 1023, 16, 32'hF0F0_F0F0));  // minor wraps past 63
		directed.push_back(make_seg(0, 1023, 1023, 0, 32'hDEAD_BEEF));
		directed.push_back(make_seg(7, 3, 9, 900, 32'h0000_FFFF));        // steep
		directed.push_back(make_seg(33, 17, 35, 18, 32'hFFFF_0000));      // one pixel, fractional
		directed.push_back(make_seg(1023, 0, 0, 1, 32'h3C3C_3C3C));       // shallow, reversed
		directed.push_back(make_seg(1, 15, 0, 16, 32'hC3C3_C3C3));
		foreach (directed[i]) begin
			send_segment(directed[i]);
			hold_off(random_gap());
		end

		drain();
		write_depth(16'hFFFF);
		random_phase(PHASE_ITEMS, 1'b1);

		// back-to-back stretch keeps the queue full
		drain();
		write_depth(DEPTH_W'($urandom));
		random_phase(PHASE_ITEMS, 1'b0);

		drain();
		write_depth(16'h0000);
		random_phase(PHASE_ITEMS, 1'b1);

		drain();
		write_depth(DEPTH_W'($urandom));
		random_phase(PHASE_ITEMS + 10, 1'b1);

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("dda_line_rasterizer_top_tb: clean");
		else
			$display("dda_line_rasterizer_top_tb: errors");
		$finish;
	end

endmodule
